// ===== hdl/bmrf_pkg.sv =====
// shared constants and types of the binary map rectangle finder
`default_nettype none
package bmrf_pkg;
    localparam int MAX_SIDE = 64;
    localparam int SIDE_W   = $clog2(MAX_SIDE);
    localparam int CNT_W    = SIDE_W + 1;
    localparam int ADDR_W   = 2 * SIDE_W;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int AREA_W   = $clog2(DEPTH + 1);
    localparam int REG_W    = 7;
    localparam int CAT_W    = 2;

    localparam logic [CAT_W-1:0] CAT_BASE   = 2'd0;
    localparam logic [CAT_W-1:0] CAT_AREA   = 2'd1;
    localparam logic [CAT_W-1:0] CAT_HEIGHT = 2'd2;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [SIDE_W-1:0] row;
        logic [SIDE_W-1:0] col;
        logic [CNT_W-1:0]  base;
        logic [CNT_W-1:0]  height;
        logic [AREA_W-1:0] area;
    } t_region;
endpackage
`default_nettype wire

// ===== hdl/bmrf_ram.sv =====
// generic single-port ram with registered read
`default_nettype none
module bmrf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== hdl/binary_map_rectangle_finder.sv =====
// top level: map load, rectangle scan and result emission
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-------------------------------------------
//  pixel   | in        | i_valid/o_ready  | i_pixel
//  result  | out       | o_valid/i_ready  | category, found, corner, sizes, area, final
//  config  | in        | apb psel/penable | row_count @0, col_count @4
//
// pixels load one per cycle into the map ram; the last pixel starts the scan.
// the scan does one ram access per cycle: a read and a check per cell, an address and
// a check per step of each run measurement, a write per cleared cell, then a region update.
// the three results are emitted in turn, each held until i_ready takes it.
// no pixel is taken during scan and emission. synchronous active-low reset.
`default_nettype none
module binary_map_rectangle_finder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_pixel,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [bmrf_pkg::CAT_W-1:0]         o_category,
    output logic                               o_found,
    output logic [bmrf_pkg::SIDE_W-1:0]        o_top_row,
    output logic [bmrf_pkg::SIDE_W-1:0]        o_left_col,
    output logic [bmrf_pkg::CNT_W-1:0]         o_width,
    output logic [bmrf_pkg::CNT_W-1:0]         o_tallness,
    output logic [bmrf_pkg::AREA_W-1:0]        o_cell_area,
    output logic                               o_final_res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    localparam int SW = bmrf_pkg::SIDE_W;
    localparam int CW = bmrf_pkg::CNT_W;

    localparam logic [3:0] ST_LOAD = 4'd0;
    localparam logic [3:0] ST_RD   = 4'd1;
    localparam logic [3:0] ST_CHK  = 4'd2;
    localparam logic [3:0] ST_B    = 4'd3;
    localparam logic [3:0] ST_BCHK = 4'd4;
    localparam logic [3:0] ST_H    = 4'd5;
    localparam logic [3:0] ST_HCHK = 4'd6;
    localparam logic [3:0] ST_CLR  = 4'd7;
    localparam logic [3:0] ST_UPD  = 4'd8;
    localparam logic [3:0] ST_EMIT = 4'd9;

    logic [3:0]                    r_state;
    logic [bmrf_pkg::REG_W-1:0]    r_row_count, r_col_count;
    logic [CW-1:0]                 rows, cols;
    logic [SW-1:0]                 r_lrow, r_lcol;
    logic [SW-1:0]                 r_i, r_j, r_cr, r_cc;
    logic [CW-1:0]                 r_b, r_h;
    bmrf_pkg::t_region             r_best [3];
    logic [1:0]                    r_k;
    logic                          cfg_wr;

    logic                          mem_we, mem_wdata, mem_rdata;
    logic [bmrf_pkg::ADDR_W-1:0]   mem_addr;
    logic [CW-1:0]                 jb, ih;
    logic [2*CW-1:0]               prod;
    logic [bmrf_pkg::AREA_W-1:0]   area;
    logic                          last_cell, last_pix;
    bmrf_pkg::t_region             rec;

    // clamp size registers to 1..MAX_SIDE
    function automatic logic [CW-1:0] eff_side(input logic [bmrf_pkg::REG_W-1:0] v);
        logic [CW-1:0] res;
        if (v == '0) begin
            res = CW'(1);
        end else if (32'(v) > bmrf_pkg::MAX_SIDE) begin
            res = CW'(bmrf_pkg::MAX_SIDE);
        end else begin
            res = CW'(v);
        end
        return res;
    endfunction

    assign rows   = eff_side(r_row_count);
    assign cols   = eff_side(r_col_count);
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == bmrf_pkg::REG_COLS) ? 32'(r_col_count) : 32'(r_row_count);
    assign o_ready = (r_state == ST_LOAD);

    assign jb   = {1'b0, r_j} + r_b;
    assign ih   = {1'b0, r_i} + r_h;
    assign prod = r_b * r_h;
    assign area = prod[bmrf_pkg::AREA_W-1:0];
    assign last_cell = ({1'b0, r_j} == cols - CW'(1)) && ({1'b0, r_i} == rows - CW'(1));
    assign last_pix  = ({1'b0, r_lcol} == cols - CW'(1)) && ({1'b0, r_lrow} == rows - CW'(1));

    always_comb begin
        rec.valid  = 1'b1;
        rec.row    = r_i;
        rec.col    = r_j;
        rec.base   = r_b;
        rec.height = r_h;
        rec.area   = area;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = 1'b0;
        mem_addr  = {r_i, r_j};
        unique case (r_state)
            ST_LOAD: begin
                mem_we    = i_valid;
                mem_wdata = i_pixel;
                mem_addr  = {r_lrow, r_lcol};
            end
            ST_B:    mem_addr = {r_i, jb[SW-1:0]};
            ST_H:    mem_addr = {ih[SW-1:0], r_j};
            ST_CLR: begin
                mem_we   = 1'b1;
                mem_addr = {r_i + r_cr, r_j + r_cc};
            end
            default: mem_addr = {r_i, r_j};
        endcase
    end

    bmrf_ram #(.WIDTH(1), .DEPTH(bmrf_pkg::DEPTH)) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_row_count <= bmrf_pkg::REG_W'(bmrf_pkg::MAX_SIDE);
            r_col_count <= bmrf_pkg::REG_W'(bmrf_pkg::MAX_SIDE);
            r_lrow      <= '0;
            r_lcol      <= '0;
            r_k         <= '0;
            o_valid     <= 1'b0;
            for (int n = 0; n < 3; n++) begin
                r_best[n] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == bmrf_pkg::REG_ROWS) begin
                    r_row_count <= pwdata[bmrf_pkg::REG_W-1:0];
                end else begin
                    r_col_count <= pwdata[bmrf_pkg::REG_W-1:0];
                end
                r_lrow <= '0;
                r_lcol <= '0;
            end
            unique case (r_state) inside
                ST_LOAD: begin
                    if (i_valid) begin
                        if (last_pix) begin
                            r_lrow  <= '0;
                            r_lcol  <= '0;
                            r_i     <= '0;
                            r_j     <= '0;
                            r_state <= ST_RD;
                            for (int n = 0; n < 3; n++) begin
                                r_best[n] <= '0;
                            end
                        end else if ({1'b0, r_lcol} == cols - CW'(1)) begin
                            r_lcol <= '0;
                            r_lrow <= r_lrow + SW'(1);
                        end else begin
                            r_lcol <= r_lcol + SW'(1);
                        end
                    end
                end
                ST_RD: r_state <= ST_CHK;
                ST_CHK, ST_UPD: begin
                    if (r_state == ST_CHK && mem_rdata) begin
                        r_b     <= CW'(1);
                        r_state <= ST_B;
                    end else begin
                        if (r_state == ST_UPD) begin
                            if (!r_best[0].valid || r_b > r_best[0].base) r_best[0] <= rec;
                            if (!r_best[1].valid || area > r_best[1].area) r_best[1] <= rec;
                            if (!r_best[2].valid || r_h > r_best[2].height) r_best[2] <= rec;
                        end
                        if (last_cell) begin
                            r_k     <= '0;
                            r_state <= ST_EMIT;
                        end else begin
                            if ({1'b0, r_j} == cols - CW'(1)) begin
                                r_j <= '0;
                                r_i <= r_i + SW'(1);
                            end else begin
                                r_j <= r_j + SW'(1);
                            end
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_B: begin
                    if (jb < cols) begin
                        r_state <= ST_BCHK;
                    end else begin
                        r_h     <= CW'(1);
                        r_state <= ST_H;
                    end
                end
                ST_BCHK: begin
                    if (mem_rdata) begin
                        r_b     <= r_b + CW'(1);
                        r_state <= ST_B;
                    end else begin
                        r_h     <= CW'(1);
                        r_state <= ST_H;
                    end
                end
                ST_H: begin
                    r_cr <= '0;
                    r_cc <= '0;
                    if (ih < rows) begin
                        r_state <= ST_HCHK;
                    end else begin
                        r_state <= ST_CLR;
                    end
                end
                ST_HCHK: begin
                    if (mem_rdata) begin
                        r_h     <= r_h + CW'(1);
                        r_state <= ST_H;
                    end else begin
                        r_state <= ST_CLR;
                    end
                end
                ST_CLR: begin
                    // sweep the rectangle row by row
                    if ({1'b0, r_cc} == r_b - CW'(1)) begin
                        r_cc <= '0;
                        if ({1'b0, r_cr} == r_h - CW'(1)) begin
                            r_state <= ST_UPD;
                        end else begin
                            r_cr <= r_cr + SW'(1);
                        end
                    end else begin
                        r_cc <= r_cc + SW'(1);
                    end
                end
                ST_EMIT: begin
                    if (!o_valid) begin
                        o_valid     <= 1'b1;
                        o_category  <= bmrf_pkg::CAT_W'(r_k);
                        o_found     <= r_best[r_k].valid;
                        o_top_row   <= r_best[r_k].row;
                        o_left_col  <= r_best[r_k].col;
                        o_width     <= r_best[r_k].base;
                        o_tallness  <= r_best[r_k].height;
                        o_cell_area <= r_best[r_k].area;
                        o_final_res <= (bmrf_pkg::CAT_W'(r_k) == bmrf_pkg::CAT_HEIGHT);
                    end else if (i_ready) begin
                        o_valid <= 1'b0;
                        if (bmrf_pkg::CAT_W'(r_k) == bmrf_pkg::CAT_HEIGHT) begin
                            r_k     <= '0;
                            r_state <= ST_LOAD;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire
